>>> rtl/fit_pkg.sv
// Package for the fault injection trigger: widths, codes and shared types.
// Used by every module of the block.
`timescale 1ns / 1ps
package fit_pkg;
   localparam int SITES_DEF = 14;
   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int SITE_W = 4;

   localparam logic [1:0] ACT_SET_PLANNED = 2'd0;
   localparam logic [1:0] ACT_APPEND_CYCLE = 2'd1;
   localparam logic [1:0] ACT_APPEND_EVENT = 2'd2;
   localparam logic [1:0] ACT_CHECK = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_ZERO_MASK = 2'd2;
   localparam logic [1:0] ST_ORDER = 2'd3;

   localparam logic CSR_TIMED_MODE = 1'b0;
   localparam logic CSR_DEFAULT_MASK = 1'b1;

   localparam logic [63:0] NEVER = '1;

   typedef struct packed {
      logic [1:0] action;
      logic [SITE_W-1:0] site;
      logic [63:0] trigger_value;
      logic [31:0] entry_mask;
      logic [63:0] now;
   } req_type;

   typedef struct packed {
      logic fire;
      logic [31:0] flip_mask;
      logic [63:0] site_events;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [0:0] index;
      logic [31:0] data;
   } csr_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic read;
      logic commit;
   } cmd_type;
endpackage

>>> rtl/fit_if.sv
// Valid/ready channel interface carrying one payload type.
`timescale 1ns / 1ps
interface fit_if #(parameter type payload_type = logic) (input logic clock);
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/fit_ctrl.sv
// Controller of the fault injection trigger: steps each request through
// read, compute/commit and response hand-off. Depends on fit_pkg.
`timescale 1ns / 1ps
module fit_ctrl import fit_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input logic rsp_ready,
   output cmd_type cmd
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0] state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = S_READ;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.commit = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_resp_after_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid) else $error("response not raised after commit");
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");
   a_read_then_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.read |=> cmd.commit) else $error("read not followed by commit");
endmodule

>>> rtl/fit_dpath.sv
// Datapath of the fault injection trigger: per-site counters, planned
// triggers, queue pointers and the queue memories. Depends on fit_pkg.
`timescale 1ns / 1ps
module fit_dpath import fit_pkg::*; #(
   parameter int SITES = SITES_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   input cmd_type cmd,
   input req_type req,
   input logic timed_mode,
   input logic [31:0] default_mask,
   output rsp_type rsp
);
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int MD = SITES * QUEUE_DEPTH;
   localparam int AW = $clog2(MD);
   localparam logic [SITE_W-1:0] SITE_NO_PLAN = SITE_W'(1);
   localparam logic [SITE_W-1:0] SITE_ALWAYS_TIMED = SITE_W'(0);
   localparam logic [SITE_W-1:0] SITE_MEM_ADDR = SITE_W'(3);
   localparam logic [SITE_W-1:0] SITE_MEM_POST = SITE_W'(4);

   logic [63:0] count_ff [SITES];
   logic [63:0] plan_ff [SITES];
   logic [QW-1:0] chead_ff [SITES];
   logic [FW-1:0] cfill_ff [SITES];
   logic [QW-1:0] ehead_ff [SITES];
   logic [FW-1:0] efill_ff [SITES];

   logic [95:0] cmem [MD];
   logic [95:0] emem [MD];

   req_type req_ff;
   logic [95:0] chead_rd_ff, ctail_rd_ff, ehead_rd_ff, etail_rd_ff;
   logic [63:0] cnt_ff, cnt3_ff, plan_rd_ff;
   logic [QW-1:0] ch_ff, eh_ff;
   logic [FW-1:0] cf_ff, ef_ff;
   rsp_type rsp_ff, rsp_in;

   logic in_range;
   logic [SITE_W-1:0] s;
   assign s = req_ff.site;
   assign in_range = (req_ff.site < SITE_W'(SITES));

   function automatic logic [AW-1:0] addr(input logic [SITE_W-1:0] site,
                                         input logic [QW:0] pos);
      logic [QW:0] p;
      p = (pos >= (QW+1)'(QUEUE_DEPTH)) ? pos - (QW+1)'(QUEUE_DEPTH) : pos;
      return AW'(site * QUEUE_DEPTH + QW'(p));
   endfunction

   // Capture the request and read everything it needs.
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req;
      if (cmd.read && in_range) begin
         cnt_ff <= count_ff[s];
         cnt3_ff <= count_ff[3];
         plan_rd_ff <= plan_ff[s];
         ch_ff <= chead_ff[s];
         cf_ff <= cfill_ff[s];
         eh_ff <= ehead_ff[s];
         ef_ff <= efill_ff[s];
         chead_rd_ff <= cmem[addr(s, {1'b0, chead_ff[s]})];
         ehead_rd_ff <= emem[addr(s, {1'b0, ehead_ff[s]})];
         ctail_rd_ff <= cmem[addr(s, (QW+1)'(chead_ff[s]) + (QW+1)'(cfill_ff[s]) - 1'b1)];
         etail_rd_ff <= emem[addr(s, (QW+1)'(ehead_ff[s]) + (QW+1)'(efill_ff[s]) - 1'b1)];
      end
   end

   logic [SITE_W-1:0] rs;
   logic rin;
   logic [63:0] cnt_new, key;
   logic plan_hit, c_hit, e_hit, app_c, app_e;
   logic [FW-1:0] fill_sel;
   logic [95:0] tail_sel;
   logic [1:0] app_status;
   assign rs = req_ff.site;
   assign rin = (req_ff.site < SITE_W'(SITES));
   assign cnt_new = cnt_ff + 64'd1;

   always_comb begin
      rsp_in = '0;
      plan_hit = 1'b0;
      c_hit = 1'b0;
      e_hit = 1'b0;
      app_c = 1'b0;
      app_e = 1'b0;
      key = '0;
      fill_sel = (req_ff.action == ACT_APPEND_CYCLE) ? cf_ff : ef_ff;
      tail_sel = (req_ff.action == ACT_APPEND_CYCLE) ? ctail_rd_ff : etail_rd_ff;
      if (req_ff.entry_mask == 32'd0) app_status = ST_ZERO_MASK;
      else if (fill_sel >= FW'(QUEUE_DEPTH)) app_status = ST_FULL;
      else if (fill_sel != '0 && req_ff.trigger_value < tail_sel[95:32])
         app_status = ST_ORDER;
      else app_status = ST_OK;
      if (rin) begin
         rsp_in.site_events = cnt_ff;
         case (req_ff.action)
            ACT_SET_PLANNED: ;
            ACT_APPEND_CYCLE: begin
               rsp_in.status = app_status;
               app_c = (app_status == ST_OK);
            end
            ACT_APPEND_EVENT: begin
               rsp_in.status = app_status;
               app_e = (app_status == ST_OK);
            end
            default: begin
               rsp_in.site_events = cnt_new;
               if (rs == SITE_ALWAYS_TIMED || timed_mode) key = req_ff.now;
               else if (rs == SITE_MEM_POST)
                  key = (SITE_MEM_ADDR == SITE_MEM_POST) ? cnt_new : cnt3_ff;
               else key = cnt_new;
               plan_hit = plan_rd_ff != NEVER && rs != SITE_NO_PLAN && key == plan_rd_ff;
               if (plan_hit) begin
                  rsp_in.fire = 1'b1;
                  rsp_in.flip_mask = default_mask;
               end else begin
                  c_hit = cf_ff != '0 && chead_rd_ff[95:32] != NEVER
                     && chead_rd_ff[95:32] == req_ff.now;
                  e_hit = ef_ff != '0 && ehead_rd_ff[95:32] != NEVER
                     && ehead_rd_ff[95:32] == cnt_new;
                  rsp_in.fire = c_hit | e_hit;
                  rsp_in.flip_mask = (c_hit ? chead_rd_ff[31:0] : 32'd0)
                     | (e_hit ? ehead_rd_ff[31:0] : 32'd0);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
         if (app_c) cmem[addr(rs, (QW+1)'(ch_ff) + (QW+1)'(cf_ff))] <=
            {req_ff.trigger_value, req_ff.entry_mask};
         if (app_e) emem[addr(rs, (QW+1)'(eh_ff) + (QW+1)'(ef_ff))] <=
            {req_ff.trigger_value, req_ff.entry_mask};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SITES; i++) begin
            count_ff[i] <= '0;
            plan_ff[i] <= NEVER;
            chead_ff[i] <= '0;
            cfill_ff[i] <= '0;
            ehead_ff[i] <= '0;
            efill_ff[i] <= '0;
         end
      end else if (cmd.commit && rin) begin
         if (req_ff.action == ACT_SET_PLANNED) plan_ff[rs] <= req_ff.trigger_value;
         if (req_ff.action == ACT_CHECK) count_ff[rs] <= cnt_new;
         if (app_c) cfill_ff[rs] <= cf_ff + 1'b1;
         if (app_e) efill_ff[rs] <= ef_ff + 1'b1;
         if (c_hit) begin
            chead_ff[rs] <= (ch_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : ch_ff + 1'b1;
            cfill_ff[rs] <= cf_ff - 1'b1;
         end
         if (e_hit) begin
            ehead_ff[rs] <= (eh_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : eh_ff + 1'b1;
            efill_ff[rs] <= ef_ff - 1'b1;
         end
      end
   end

   assign rsp = rsp_ff;

   a_plan_excl: assert property (@(posedge clock) disable iff (reset)
      plan_hit |-> !c_hit && !e_hit) else $error("queue popped on planned hit");
   a_app_excl: assert property (@(posedge clock) disable iff (reset)
      !(app_c && app_e)) else $error("two appends at once");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && rin |-> cf_ff <= FW'(QUEUE_DEPTH) && ef_ff <= FW'(QUEUE_DEPTH))
      else $error("fill above depth");
endmodule

>>> rtl/fault_injection_trigger.sv
// Fault injection trigger, top level: controller, datapath, config registers.
// A request passes through the read, compute and response steps of the controller;
// only one request is in flight, so a new request is accepted only after the
// response has been taken.
// Reset (synchronous) clears counts, queues and config; planned triggers read never.
`timescale 1ns / 1ps
module fault_injection_trigger import fit_pkg::*; #(
   parameter int SITES = SITES_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   fit_if.sink req,
   fit_if.source rsp,
   fit_if.sink csr
);
   cmd_type cmd;
   logic timed_mode_ff;
   logic [31:0] default_mask_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         timed_mode_ff <= 1'b0;
         default_mask_ff <= '0;
      end else if (csr.valid) begin
         if (csr.data.index == CSR_TIMED_MODE) timed_mode_ff <= csr.data.data[0];
         else default_mask_ff <= csr.data.data;
      end
   end

   fit_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd)
   );

   fit_dpath #(.SITES(SITES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .req(req.data),
      .timed_mode(timed_mode_ff), .default_mask(default_mask_ff),
      .rsp(rsp.data)
   );
endmodule

>>> sim/tb_fault_injection_trigger.sv
// Testbench for the fault injection trigger: directed and random requests
// with a predictor and a response checker. Depends on fit_pkg and fit_if.
`timescale 1ns / 1ps
module tb_fault_injection_trigger;
   import fit_pkg::*;

   localparam int NSITES = 14;
   localparam int QDEPTH = 8;
   localparam int WATCHDOG_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   fit_if #(.payload_type(req_type)) req (clock);
   fit_if #(.payload_type(rsp_type)) rsp (clock);
   fit_if #(.payload_type(csr_type)) csr (clock);

   fault_injection_trigger dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   // Predictor state.
   logic timed_mode;
   logic [31:0] default_mask;
   logic [63:0] site_count [NSITES];
   logic [63:0] planned [NSITES];
   logic [63:0] cyc_when [NSITES][QDEPTH];
   logic [31:0] cyc_mask [NSITES][QDEPTH];
   logic [63:0] evt_when [NSITES][QDEPTH];
   logic [31:0] evt_mask [NSITES][QDEPTH];
   int cyc_head [NSITES], cyc_fill [NSITES], evt_head [NSITES], evt_fill [NSITES];

   rsp_type expected_rsps [$];
   int mismatches = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   function automatic logic [1:0] append_entry(input logic is_event, input int s,
                                               input logic [63:0] w,
                                               input logic [31:0] m);
      int h, f;
      h = is_event ? evt_head[s] : cyc_head[s];
      f = is_event ? evt_fill[s] : cyc_fill[s];
      if (m == 0) return ST_ZERO_MASK;
      if (f >= QDEPTH) return ST_FULL;
      if (f > 0) begin
         if (w < (is_event ? evt_when[s][(h + f - 1) % QDEPTH]
                           : cyc_when[s][(h + f - 1) % QDEPTH])) return ST_ORDER;
      end
      if (is_event) begin
         evt_when[s][(h + f) % QDEPTH] = w;
         evt_mask[s][(h + f) % QDEPTH] = m;
         evt_fill[s]++;
      end else begin
         cyc_when[s][(h + f) % QDEPTH] = w;
         cyc_mask[s][(h + f) % QDEPTH] = m;
         cyc_fill[s]++;
      end
      return ST_OK;
   endfunction

   function automatic rsp_type predict_trigger(input req_type r);
      rsp_type o;
      int s;
      logic [63:0] key;
      logic hit;
      o = '0;
      if (r.site >= NSITES) return o;
      s = r.site;
      case (r.action)
         ACT_SET_PLANNED: planned[s] = r.trigger_value;
         ACT_APPEND_CYCLE: o.status = append_entry(1'b0, s, r.trigger_value, r.entry_mask);
         ACT_APPEND_EVENT: o.status = append_entry(1'b1, s, r.trigger_value, r.entry_mask);
         default: begin
            site_count[s]++;
            if (s == 0 || timed_mode) key = r.now;
            else if (s == 4) key = site_count[3];
            else key = site_count[s];
            if (planned[s] != NEVER && s != 1 && key == planned[s]) begin
               o.fire = 1'b1;
               o.flip_mask = default_mask;
            end else begin
               hit = 1'b0;
               if (cyc_fill[s] > 0 && cyc_when[s][cyc_head[s]] != NEVER
                     && cyc_when[s][cyc_head[s]] == r.now) begin
                  hit = 1'b1;
                  o.flip_mask |= cyc_mask[s][cyc_head[s]];
                  cyc_head[s] = (cyc_head[s] + 1) % QDEPTH;
                  cyc_fill[s]--;
               end
               if (evt_fill[s] > 0 && evt_when[s][evt_head[s]] != NEVER
                     && evt_when[s][evt_head[s]] == site_count[s]) begin
                  hit = 1'b1;
                  o.flip_mask |= evt_mask[s][evt_head[s]];
                  evt_head[s] = (evt_head[s] + 1) % QDEPTH;
                  evt_fill[s]--;
               end
               o.fire = hit;
            end
         end
      endcase
      o.site_events = site_count[s];
      return o;
   endfunction

   task automatic send_request(input req_type r);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      expected_rsps.insert(expected_rsps.size(), predict_trigger(r));
   endtask

   task automatic send(input logic [1:0] a, input logic [3:0] s, input logic [63:0] tv,
                       input logic [31:0] m, input logic [63:0] n);
      req_type r;
      r.action = a;
      r.site = s;
      r.trigger_value = tv;
      r.entry_mask = m;
      r.now = n;
      send_request(r);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] v);
      csr.valid <= 1'b1;
      csr.data <= '{index: idx, data: v};
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      if (idx == CSR_TIMED_MODE) timed_mode = v[0];
      else default_mask = v;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected response %p", rsp.data);
            end else if (rsp.data !== expected_rsps[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %p, got %p", expected_rsps[0], rsp.data);
               void'(expected_rsps.pop_front());
            end else begin
               void'(expected_rsps.pop_front());
            end
         end
         rsp.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_directed();
      // Extremes, each action, out-of-range sites and append error cases.
      send(ACT_CHECK, 4'd15, '1, '1, '1);
      send(ACT_CHECK, 4'd14, '0, '0, '0);
      send(ACT_APPEND_CYCLE, 4'd2, 64'd5, 32'd0, '0);
      send(ACT_APPEND_CYCLE, 4'd2, 64'd9, 32'hFFFF_FFFF, '0);
      send(ACT_APPEND_CYCLE, 4'd2, 64'd7, 32'h1, '0);
      send(ACT_APPEND_CYCLE, 4'd2, 64'd9, 32'h2, '0);
      send(ACT_CHECK, 4'd2, '0, '0, 64'd9);
      send(ACT_CHECK, 4'd2, '0, '0, 64'd9);
      send(ACT_APPEND_EVENT, 4'd13, '1, 32'h8000_0000, '0);
      send(ACT_CHECK, 4'd13, '0, '0, '1);
      for (int i = 0; i < 9; i++) send(ACT_APPEND_EVENT, 4'd5, 64'(i + 1), 32'h10, '0);
      send(ACT_CHECK, 4'd5, '0, '0, '0);
      send(ACT_SET_PLANNED, 4'd0, 64'd100, '0, '0);
      send(ACT_CHECK, 4'd0, '0, '0, 64'd100);
      send(ACT_SET_PLANNED, 4'd1, 64'd1, '0, '0);
      send(ACT_CHECK, 4'd1, '0, '0, 64'd1);
      send(ACT_SET_PLANNED, 4'd4, 64'd1, '0, '0);
      send(ACT_CHECK, 4'd3, '0, '0, '0);
      send(ACT_CHECK, 4'd4, '0, '0, '0);
      send(ACT_SET_PLANNED, 4'd6, '1, '1, '1);
      send(ACT_CHECK, 4'd6, '1, '1, '1);
      drain();
   endtask

   task automatic test_random(input int count);
      logic [1:0] a;
      logic [3:0] s;
      logic [63:0] tv, n;
      logic [31:0] m;
      for (int i = 0; i < count; i++) begin
         a = 2'($urandom_range(3));
         s = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(13));
         m = ($urandom_range(15) == 0) ? '0 : (($urandom_range(3) == 0) ? $urandom()
                                                  : 32'(1) << $urandom_range(31));
         n = 64'($urandom_range(12));
         if (s < NSITES) begin
            // Often values near the current count so that triggers hit.
            case ($urandom_range(7))
               0: tv = {$urandom(), $urandom()};
               1: tv = '1;
               2, 3: tv = 64'($urandom_range(12));
               default: tv = site_count[s] + 64'($urandom_range(4));
            endcase
            if ($urandom_range(3) == 0) n = {$urandom(), $urandom()};
         end else begin
            tv = {$urandom(), $urandom()};
         end
         send(a, s, tv, m, n);
      end
   endtask

   task automatic test_phase(input int sidle, input int rstall, input logic tm,
                             input logic [31:0] dm, input int count);
      drain();
      write_csr(CSR_TIMED_MODE, {31'd0, tm});
      write_csr(CSR_DEFAULT_MASK, dm);
      csr.valid <= 1'b0;
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      test_random(count);
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      timed_mode = 1'b0;
      default_mask = '0;
      for (int i = 0; i < NSITES; i++) begin
         site_count[i] = '0;
         planned[i] = NEVER;
         cyc_head[i] = 0; cyc_fill[i] = 0; evt_head[i] = 0; evt_fill[i] = 0;
      end
      req.valid = 1'b0;
      req.data = '0;
      csr.valid = 1'b0;
      csr.data = '0;
      rsp.ready = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_csr(CSR_DEFAULT_MASK, 32'hA5A5_0F0F);
      csr.valid <= 1'b0;
      test_directed();
      test_phase(0, 0, 1'b0, 32'hFFFF_FFFF, 450);
      test_phase(88, 0, 1'b1, 32'h0, 300);
      test_phase(0, 88, 1'b0, 32'h0000_0001, 300);
      test_phase(9, 9, 1'b1, 32'h8000_0000, 450);
      test_phase(0, 0, 1'b0, 32'h1234_5678, 300);
      drain();
      if (mismatches == 0 && expected_rsps.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      wait (!reset);
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end
endmodule
